[rtl/acgs_pkg.sv]
package acgs_pkg;

  localparam int MAX_VOICES = 8;
  localparam int IDX_W = $clog2(MAX_VOICES);
  localparam int CNT_W = $clog2(MAX_VOICES + 1);
  localparam int TOTAL_W = CNT_W + 15;
  localparam logic [15:0] UNITY = 16'h8000;
  localparam logic [15:0] FADE_STEP_RESET = 16'd327;

  typedef enum logic [1:0] {
    OP_PLAY    = 2'd0,
    OP_TICK    = 2'd1,
    OP_REFRESH = 2'd2,
    OP_STOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_LEVEL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_RD,
    S_EV,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t         opcode;
    logic [7:0]  source_id;
    logic [15:0] level_factor;
    logic        paused;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  voice_id;
    logic [15:0] applied_gain;
    logic [15:0] fade_gain;
    logic        removed;
    logic        started;
    logic        voice_paused;
    status_t     status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] fade;
    logic [15:0] level;
  } voice_t;

endpackage

[rtl/acgs_ram.sv]
module acgs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/acgs_gain.sv]
module acgs_gain (
  input  logic [15:0] level,
  input  logic [15:0] fade,
  output logic [15:0] gain
);
  import acgs_pkg::*;

  logic [31:0] prod;
  logic [32:0] rounded;
  logic [17:0] g;

  assign prod = level * fade;
  assign rounded = {1'b0, prod} + 33'd16384;
  assign g = rounded[32:15];
  assign gain = (g > {2'b00, UNITY}) ? UNITY : g[15:0];

endmodule

[rtl/audio_crossfade_gain_scheduler.sv]
// Crossfade gain scheduler. A command is taken when start is high and busy is low.
// After the accepting cycle, a play does one read and one compare of the voice memory
// per voice walked, then a write-back step and a result step; a play with a level
// factor above one goes straight to its result. A tick or refresh does a read, an
// update and a result step per voice, and a running tick first reads the newest voice.
// Stop all, and a tick or refresh of an empty table, give no result beat. Each result
// beat is shown for exactly one cycle with result_valid high and cannot be held off, so
// the receiver must take every beat as it comes. The fade_step register is written
// through cfg_data whenever cfg_valid is high and should only change while idle.
module audio_crossfade_gain_scheduler (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  acgs_pkg::cmd_t    cmd,
  output logic              result_valid,
  output acgs_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import acgs_pkg::*;

  state_t state, state_next;
  cmd_t cmd_q;
  logic [15:0] fstep;
  logic [CNT_W-1:0] count;
  logic [TOTAL_W-1:0] total;
  logic [CNT_W-1:0] rd;
  logic [CNT_W-1:0] wr;
  logic [15:0] rise;
  logic run;
  logic found;
  logic [15:0] found_fade;
  logic [7:0] id_q;
  logic [15:0] f_q;
  logic [15:0] lvl_q;
  logic gone_q, started_q, last_q;
  status_t status_q;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  voice_t ram_wdata, ram_rdata;
  logic [15:0] gain;

  logic [CNT_W-1:0] top;
  logic is_last;
  logic [16:0] f_up;
  logic [TOTAL_W-1:0] total_ev;
  logic [TOTAL_W-1:0] excess;
  logic [15:0] dd;
  logic [15:0] f_ev;
  logic gone;
  logic [16:0] room;
  logic [16:0] rise_new;
  logic match;
  logic full;

  acgs_ram #(.WIDTH($bits(voice_t)), .DEPTH(MAX_VOICES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  acgs_gain u_gain (
    .level (lvl_q),
    .fade  (f_q),
    .gain  (gain)
  );

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign top = count - CNT_W'(1);
  assign is_last = (rd == top);
  assign match = (ram_rdata.id == cmd_q.source_id);
  assign full = !found && (count == CNT_W'(MAX_VOICES));
  assign room = {1'b0, UNITY} - {1'b0, ram_rdata.fade};
  assign rise_new = ({1'b0, fstep} < room) ? {1'b0, fstep} : room;

  always_comb begin
    f_up = {1'b0, ram_rdata.fade};
    if (run && is_last) begin
      f_up = {1'b0, ram_rdata.fade} + {1'b0, rise};
    end
    f_ev = f_up[15:0];
    total_ev = total;
    excess = '0;
    dd = '0;
    gone = 1'b0;
    if (total > TOTAL_W'(UNITY)) begin
      excess = total - TOTAL_W'(UNITY);
    end
    if (run && excess != '0) begin
      dd = f_ev;
      if (rise < dd) begin
        dd = rise;
      end
      if (excess < TOTAL_W'(dd)) begin
        dd = excess[15:0];
      end
      f_ev = f_ev - dd;
      total_ev = total - TOTAL_W'(dd);
      gone = (f_ev == 16'd0);
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = wr[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = rd[IDX_W-1:0];
    if (state == S_IDLE) begin
      ram_raddr = top[IDX_W-1:0];
    end
    case (state)
      S_EV: begin
        if (cmd_q.opcode == OP_PLAY) begin
          ram_we = !match;
        end else begin
          ram_we = !gone;
          ram_wdata.fade = f_ev;
        end
      end
      S_FIN: begin
        ram_we = !full;
        ram_wdata.id = cmd_q.source_id;
        ram_wdata.fade = found ? found_fade : 16'd0;
        ram_wdata.level = cmd_q.level_factor;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd.opcode)
            OP_PLAY: begin
              if (cmd.level_factor > UNITY) begin
                state_next = S_OUT;
              end else if (count == '0) begin
                state_next = S_FIN;
              end else begin
                state_next = S_RD;
              end
            end
            OP_TICK: begin
              if (count == '0) begin
                state_next = S_IDLE;
              end else if (!cmd.paused) begin
                state_next = S_TOP;
              end else begin
                state_next = S_RD;
              end
            end
            OP_REFRESH: begin
              state_next = (count == '0) ? S_IDLE : S_RD;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_TOP: state_next = S_RD;
      S_RD: state_next = S_EV;
      S_EV: begin
        if (cmd_q.opcode == OP_PLAY) begin
          state_next = is_last ? S_FIN : S_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_FIN: state_next = S_OUT;
      S_OUT: state_next = last_q ? S_IDLE : S_RD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstep <= FADE_STEP_RESET;
      count <= '0;
      total <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        fstep <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            rd <= '0;
            wr <= '0;
            found <= 1'b0;
            found_fade <= '0;
            run <= (cmd.opcode == OP_TICK) && !cmd.paused;
            rise <= '0;
            id_q <= cmd.source_id;
            f_q <= '0;
            lvl_q <= '0;
            gone_q <= 1'b0;
            started_q <= 1'b0;
            last_q <= 1'b1;
            status_q <= ST_LEVEL;
            if (cmd.opcode == OP_STOP) begin
              count <= '0;
              total <= '0;
            end
          end
        end
        S_TOP: begin
          rise <= rise_new[15:0];
          total <= total + TOTAL_W'(rise_new);
        end
        S_EV: begin
          if (cmd_q.opcode == OP_PLAY) begin
            if (match) begin
              found <= 1'b1;
              found_fade <= ram_rdata.fade;
            end else begin
              wr <= wr + CNT_W'(1);
            end
            rd <= rd + CNT_W'(1);
          end else begin
            total <= total_ev;
            if (!gone) begin
              wr <= wr + CNT_W'(1);
            end
            id_q <= ram_rdata.id;
            f_q <= gone ? 16'd0 : f_ev;
            lvl_q <= gone ? 16'd0 : ram_rdata.level;
            gone_q <= gone;
            started_q <= 1'b0;
            last_q <= is_last;
            status_q <= ST_OK;
          end
        end
        S_FIN: begin
          last_q <= 1'b1;
          if (full) begin
            status_q <= ST_FULL;
          end else begin
            status_q <= ST_OK;
            f_q <= found ? found_fade : 16'd0;
            lvl_q <= cmd_q.level_factor;
            started_q <= !found;
            if (!found) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        S_OUT: begin
          result_valid <= 1'b1;
          result.voice_id <= id_q;
          result.applied_gain <= gain;
          result.fade_gain <= f_q;
          result.removed <= gone_q;
          result.started <= started_q;
          result.voice_paused <= (cmd_q.opcode != OP_PLAY) && cmd_q.paused;
          result.status <= status_q;
          result.last <= last_q;
          rd <= rd + CNT_W'(1);
          if (last_q && cmd_q.opcode != OP_PLAY) begin
            count <= wr;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
